// ===== hdl/gae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_pkg
// Types, widths and helpers shared by the advantage estimator modules.
// ----------------------------------------------------------------------------
package gae_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 17;
  localparam int DIV_W  = 70;  // dividend width of the shared divider
  localparam int DEN_W  = 33;  // divisor width
  localparam int ITER_W = 7;   // iteration count width
  localparam int SUM_W  = 38;  // sum of up to 64 advantages
  localparam int ACC_W  = 70;  // sum of up to 64 squared deviations
  localparam int PROD_W = 52;

  localparam logic [CFG_W-1:0] ONE_Q16        = 17'h10000;
  localparam logic [CFG_W-1:0] DISCOUNT_RST   = 17'd64880;
  localparam logic [CFG_W-1:0] TRACE_DECAY_RST = 17'd62259;

  localparam logic CFG_DISCOUNT    = 1'b0;
  localparam logic CFG_TRACE_DECAY = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] reward;
    logic signed [DATA_W-1:0] state_value;
    logic signed [DATA_W-1:0] bootstrap_value;
    logic                     terminal;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] advantage;
    logic signed [DATA_W-1:0] return_value;
    logic                     last_result;
  } result_t;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_GL   = 16'h0002,
    S_GLW  = 16'h0004,
    S_BRD  = 16'h0008,
    S_BM1  = 16'h0010,
    S_BADD = 16'h0020,
    S_MST  = 16'h0040,
    S_MWT  = 16'h0080,
    S_VRD  = 16'h0100,
    S_VD   = 16'h0200,
    S_VM1  = 16'h0400,
    S_VM2  = 16'h0800,
    S_VM3  = 16'h1000,
    S_VWT  = 16'h2000,
    S_SQ   = 16'h4000,
    S_NRUN = 16'h8000
  } state_e;

  typedef enum logic [2:0] {
    N_RD  = 3'b001,
    N_DIV = 3'b010,
    N_WT  = 3'b100
  } nstep_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh007FFFFFFF;
    lo = -40'sh0080000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

  function automatic logic [CFG_W-1:0] clamp_one(input logic [CFG_W-1:0] v);
    clamp_one = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

// ===== hdl/gae_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_div
// Restoring divider, one quotient bit per cycle, dividend MSB aligned.
// ----------------------------------------------------------------------------
module gae_div import gae_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [ITER_W-1:0] iters_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o,
  output logic [DEN_W-1:0]  rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  num_q, num_d;
  logic [DIV_W-1:0]  quot_q, quot_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, num_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      num_d  = num_i;
      quot_d = '0;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d  = {num_q[DIV_W-2:0], 1'b0};
      quot_d = {quot_q[DIV_W-2:0], ge};
      rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/gae_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gae_sqrt import gae_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [63:0]       value_i,
  output logic              done_o,
  output logic [DATA_W-1:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] v_q, v_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      v_d    = value_i;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[DATA_W-1:0];

endmodule

// ===== hdl/generalized_advantage_estimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generalized_advantage_estimator_core
// Trajectory store, GAE backward pass and normalised forward output.
// ----------------------------------------------------------------------------
// Steps load while busy is low. The step flagged last starts the computation
// and busy rises until the final result has gone out. For n stored steps the
// run does the backward recursion, the mean division, the squared deviations
// (one shared 18x34 multiplier, two partial products per step), the variance
// division, the square root and the normalisation, where every step goes
// through the bit-serial divider. Results come out one per strobe, in forward
// order, spaced by the divider; the receiver cannot stall, so each result is
// valid for exactly the one cycle that res_valid_o is high.
module generalized_advantage_estimator_core import gae_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  item_t            item_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW = $clog2(MAX_STEPS + 1);

  // configuration
  logic [CFG_W-1:0] discount_q, trace_decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discount_q    <= DISCOUNT_RST;
      trace_decay_q <= TRACE_DECAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DISCOUNT:    discount_q    <= cfg_data_i;
        CFG_TRACE_DECAY: trace_decay_q <= cfg_data_i;
        default:         discount_q    <= discount_q;
      endcase
    end
  end

  // control
  state_e  state_q, state_d;
  nstep_e  nstep_q, nstep_d;
  logic [CW-1:0] step_cnt_q, step_cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] last_idx;
  logic          accept;
  logic          full;
  logic [AW-1:0] slot;
  logic          load_we;
  logic          res_valid_q, res_valid_d;

  // datapath
  logic [CFG_W-1:0]         gamma_q, gamma_d;
  logic [CFG_W-1:0]         gl_q, gl_d;
  logic signed [DATA_W-1:0] next_v_q, next_v_d;
  logic signed [DATA_W-1:0] adv_q, adv_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [DATA_W-1:0] mean_q, mean_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [DEN_W-1:0]         m_q, m_d;
  logic [DEN_W-1:0]         denom_q, denom_d;
  logic signed [PROD_W-1:0] p1_q, p1_d;
  result_t                  res_q, res_d;

  // memories
  logic signed [DATA_W-1:0] reward_mem [MAX_STEPS];
  logic signed [DATA_W-1:0] value_mem  [MAX_STEPS];
  logic                     term_mem   [MAX_STEPS];
  logic signed [DATA_W-1:0] adv_mem    [MAX_STEPS];
  logic signed [DATA_W-1:0] reward_rd, value_rd, adv_rd;
  logic                     term_rd;
  logic                     adv_we;

  // shared multiplier
  logic signed [17:0]       mul_a;
  logic signed [33:0]       mul_b;
  logic signed [PROD_W-1:0] prod_q;

  // divider and square root
  logic              div_start, div_busy, div_done;
  logic [DIV_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den, div_rem;
  logic [ITER_W-1:0] div_iters;
  logic              sq_start, sq_done;
  logic [DATA_W-1:0] sq_root;

  // arithmetic temporaries
  logic signed [PROD_W-1:0] p1_rnd, p2_rnd;
  logic signed [39:0]       delta, adv_sum, term_diff;
  logic signed [DATA_W-1:0] adv_new;
  logic [SUM_W-1:0]         sum_mag;
  logic signed [39:0]       mean_full;
  logic signed [DATA_W:0]   dev;
  logic [DEN_W-1:0]         dev_mag;
  logic [48:0]              norm_num;
  logic [48:0]              q_norm;
  logic signed [DATA_W-1:0] norm_val;

  assign accept   = start && !busy;
  assign full     = step_cnt_q >= CW'(MAX_STEPS);
  assign slot     = full ? AW'(MAX_STEPS - 1) : step_cnt_q[AW-1:0];
  assign load_we  = accept && (!full || item_i.last);
  assign last_idx = AW'(n_q - CW'(1));
  assign busy     = (state_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      reward_mem[slot] <= item_i.reward;
      value_mem[slot]  <= item_i.state_value;
      term_mem[slot]   <= item_i.terminal;
    end
    if (adv_we) begin
      adv_mem[idx_q] <= adv_new;
    end
    reward_rd <= reward_mem[idx_q];
    value_rd  <= value_mem[idx_q];
    term_rd   <= term_mem[idx_q];
    adv_rd    <= adv_mem[idx_q];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GL: begin
        mul_a = {1'b0, clamp_one(discount_q)};
        mul_b = {17'b0, clamp_one(trace_decay_q)};
      end
      S_BRD: begin
        mul_a = {1'b0, gamma_q};
        mul_b = 34'(next_v_q);
      end
      S_BM1: begin
        mul_a = {1'b0, gl_q};
        mul_b = 34'(adv_q);
      end
      S_VM1: begin
        mul_a = {2'b0, m_q[15:0]};
        mul_b = {1'b0, m_q};
      end
      S_VM2: begin
        mul_a = {1'b0, m_q[32:16]};
        mul_b = {1'b0, m_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // backward step arithmetic
  always_comb begin
    p1_rnd    = (p1_q + PROD_W'(32768)) >>> 16;
    p2_rnd    = (prod_q + PROD_W'(32768)) >>> 16;
    term_diff = 40'(reward_rd) - 40'(value_rd);
    delta     = 40'(reward_rd) + p1_rnd[39:0] - 40'(value_rd);
    adv_sum   = delta + p2_rnd[39:0];
    adv_new   = term_rd ? sat32(term_diff) : sat32(adv_sum);
  end

  // mean, deviation and normalisation arithmetic
  always_comb begin
    sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    mean_full = sum_q[SUM_W-1]
              ? -(40'($signed({2'b0, div_quot[SUM_W-1:0]})) + 40'(div_rem != '0))
              : 40'($signed({2'b0, div_quot[SUM_W-1:0]}));
    dev       = (DATA_W+1)'(adv_rd) - (DATA_W+1)'(mean_q);
    dev_mag   = dev[DATA_W] ? DEN_W'(-dev) : DEN_W'(dev);
    norm_num  = {dev_mag, 16'b0} + 49'(denom_q >> 1);
    q_norm    = div_quot[48:0];
    if (!dev[DATA_W]) begin
      norm_val = (q_norm > 49'h7FFFFFFF) ? 32'sh7FFFFFFF : q_norm[DATA_W-1:0];
    end else begin
      norm_val = (q_norm > 49'h80000000) ? 32'sh80000000 : -q_norm[DATA_W-1:0];
    end
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DEN_W'(n_q);
    div_iters = ITER_W'(SUM_W);
    case (state_q)
      S_MST: begin
        div_start = 1'b1;
        div_num   = {sum_mag, 32'b0};
      end
      S_VWT: begin
        div_start = 1'b0;
        div_num   = acc_q;
      end
      S_NRUN: begin
        div_start = (nstep_q == N_DIV);
        div_num   = {norm_num, 21'b0};
        div_den   = denom_q;
        div_iters = ITER_W'(49);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    nstep_d     = nstep_q;
    step_cnt_d  = step_cnt_q;
    n_d         = n_q;
    idx_d       = idx_q;
    gamma_d     = gamma_q;
    gl_d        = gl_q;
    next_v_d    = next_v_q;
    adv_d       = adv_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    acc_d       = acc_q;
    m_d         = m_q;
    denom_d     = denom_q;
    p1_d        = p1_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    adv_we      = 1'b0;
    sq_start    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (load_we) begin
          idx_d      = slot;
          step_cnt_d = CW'(slot) + CW'(1);
          n_d        = CW'(slot) + CW'(1);
          next_v_d   = item_i.bootstrap_value;
          if (item_i.last) begin
            state_d = S_GL;
          end
        end
      end
      S_GL: begin
        gamma_d = clamp_one(discount_q);
        state_d = S_GLW;
      end
      S_GLW: begin
        gl_d    = CFG_W'((prod_q + PROD_W'(32768)) >>> 16);
        adv_d   = '0;
        sum_d   = '0;
        state_d = S_BRD;
      end
      S_BRD: begin
        state_d = S_BM1;
      end
      S_BM1: begin
        p1_d    = prod_q;
        state_d = S_BADD;
      end
      S_BADD: begin
        adv_we   = 1'b1;
        adv_d    = adv_new;
        sum_d    = sum_q + SUM_W'(adv_new);
        next_v_d = value_rd;
        if (idx_q == '0) begin
          state_d = S_MST;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_BRD;
        end
      end
      S_MST: begin
        state_d = S_MWT;
      end
      S_MWT: begin
        if (div_done) begin
          mean_d  = mean_full[DATA_W-1:0];
          idx_d   = '0;
          acc_d   = '0;
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        state_d = S_VD;
      end
      S_VD: begin
        m_d     = dev_mag;
        state_d = S_VM1;
      end
      S_VM1: begin
        state_d = S_VM2;
      end
      S_VM2: begin
        acc_d   = acc_q + ACC_W'(prod_q[PROD_W-2:0]);
        state_d = S_VM3;
      end
      S_VM3: begin
        acc_d = acc_q + (ACC_W'(prod_q[PROD_W-2:0]) << 16);
        if (idx_q == last_idx) begin
          state_d = S_VWT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_VRD;
        end
      end
      S_VWT: begin
        // variance division is started by the registered var_start_q pulse on entry here; div_start stays low
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        if (sq_done) begin
          denom_d = DEN_W'(sq_root) + DEN_W'(1);
          idx_d   = '0;
          nstep_d = N_RD;
          state_d = S_NRUN;
        end
      end
      S_NRUN: begin
        case (nstep_q)
          N_RD:  nstep_d = N_DIV;
          N_DIV: nstep_d = N_WT;
          N_WT: begin
            if (div_done) begin
              res_d.advantage    = norm_val;
              res_d.return_value = sat32(40'(adv_rd) + 40'(value_rd));
              res_d.last_result  = (idx_q == last_idx);
              res_valid_d        = 1'b1;
              if (idx_q == last_idx) begin
                step_cnt_d = '0;
                state_d    = S_IDLE;
              end else begin
                idx_d   = idx_q + 1'b1;
                nstep_d = N_RD;
              end
            end
          end
          default: nstep_d = N_RD;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the variance division needs a start pulse of its own on entry to S_VWT
  logic var_start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_start_q <= 1'b0;
    end else begin
      var_start_q <= (state_q == S_VM3) && (state_d == S_VWT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nstep_q     <= N_RD;
      step_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nstep_q     <= nstep_d;
      step_cnt_q  <= step_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    idx_q    <= idx_d;
    gamma_q  <= gamma_d;
    gl_q     <= gl_d;
    next_v_q <= next_v_d;
    adv_q    <= adv_d;
    sum_q    <= sum_d;
    mean_q   <= mean_d;
    acc_q    <= acc_d;
    m_q      <= m_d;
    denom_q  <= denom_d;
    p1_q     <= p1_d;
    res_q    <= res_d;
  end

  gae_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start || var_start_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (var_start_q ? ITER_W'(ACC_W) : div_iters),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  gae_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (div_quot[63:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_result |-> state_q == S_IDLE)
    else $error("final item out while still running");

  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_result |-> busy)
    else $error("non-final item out while idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_cnt_q <= CW'(MAX_STEPS))
    else $error("step count beyond capacity");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_start || var_start_q) |-> !div_busy)
    else $error("divider started while busy");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.last |=> state_q == S_GL)
    else $error("last item did not start the run");

endmodule

// ===== tb/generalized_advantage_estimator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generalized_advantage_estimator_core_tb
// Drives trajectories through the advantage estimator and checks every result.
// A scoreboard keeps its own copy of the step stores and both registers. When a
// last step is accepted, it runs the backward recursion and the normalisation,
// then queues the results. Each strobed result is compared with the oldest one
// still queued.
// ----------------------------------------------------------------------------
module generalized_advantage_estimator_core_tb;
  import gae_pkg::*;

  localparam int DEPTH = 64;

  class gae_scoreboard;
    logic [CFG_W-1:0] discount_q16;
    logic [CFG_W-1:0] decay_q16;
    longint           rewards[DEPTH];
    longint           values[DEPTH];
    bit               terminals[DEPTH];
    longint           advs[DEPTH];
    int               stored;
    result_t          expected_results[$];
    int               errors;

    function new();
      discount_q16 = DISCOUNT_RST;
      decay_q16    = TRACE_DECAY_RST;
      stored       = 0;
      errors       = 0;
    endfunction

    // floor((x + 2^15) / 2^16)
    function longint round_q16(longint x);
      return (x + 32768) >>> 16;
    endfunction

    function longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_item(item_t it);
      int          slot;
      int          n;
      longint      gamma;
      longint      gl;
      longint      adv;
      longint      next_v;
      longint      sum;
      longint      mean;
      longint      d;
      longint      delta;
      longint      q;
      logic [127:0] acc;
      logic [127:0] m;
      logic [63:0] sd;
      logic [63:0] denom;
      result_t     r;
      if (stored >= DEPTH) begin
        if (!it.last) return;
        slot = DEPTH - 1;
      end else begin
        slot = stored;
      end
      rewards[slot]   = longint'(it.reward);
      values[slot]    = longint'(it.state_value);
      terminals[slot] = it.terminal;
      n      = slot + 1;
      stored = n;
      if (!it.last) return;

      gamma  = (discount_q16 > ONE_Q16) ? 65536 : longint'(discount_q16);
      gl     = round_q16(gamma * ((decay_q16 > ONE_Q16) ? 65536 : longint'(decay_q16)));
      next_v = longint'(it.bootstrap_value);
      adv    = 0;
      sum    = 0;
      for (int i = n - 1; i >= 0; i--) begin
        if (terminals[i]) begin
          adv = sat_word(rewards[i] - values[i]);
        end else begin
          delta = rewards[i] + round_q16(gamma * next_v) - values[i];
          adv   = sat_word(delta + round_q16(gl * adv));
        end
        advs[i] = adv;
        sum    += adv;
        next_v  = values[i];
      end
      if (sum >= 0) mean = sum / n;
      else mean = -((-sum + n - 1) / n);

      acc = 0;
      for (int i = 0; i < n; i++) begin
        d   = advs[i] - mean;
        m   = (d < 0) ? -d : d;
        acc = acc + m * m;
      end
      sd    = int_sqrt(64'(acc / n));
      denom = sd + 1;

      for (int i = 0; i < n; i++) begin
        d = advs[i] - mean;
        q = longint'(((((d < 0) ? -d : d) << 16) + denom / 2) / denom);
        r.advantage    = 32'(sat_word((d < 0) ? -q : q));
        r.return_value = 32'(sat_word(advs[i] + values[i]));
        r.last_result  = (i == n - 1);
        expected_results.push_back(r);
      end
      stored = 0;
    endfunction

    function void check(result_t got);
      result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.advantage !== exp_r.advantage) begin
        $display("%0t: advantage expected %0d got %0d", $time,
                 exp_r.advantage, got.advantage);
        errors++;
      end
      if (got.return_value !== exp_r.return_value) begin
        $display("%0t: return_value expected %0d got %0d", $time,
                 exp_r.return_value, got.return_value);
        errors++;
      end
      if (got.last_result !== exp_r.last_result) begin
        $display("%0t: last_result expected %0b got %0b", $time,
                 exp_r.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  item_t            item_i;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             res_valid_o;
  result_t          res_o;

  gae_scoreboard sb = new();
  int            idle_pct;
  int            sent;

  generalized_advantage_estimator_core #(.MAX_STEPS(DEPTH)) dut (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .res_valid_o, .res_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check(res_o);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      2: begin
        case ($urandom_range(0, 2))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          default: return 32'h0;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  task automatic send_step(item_t it);
    @(negedge clk_i);
    while (busy || ($urandom_range(0, 99) < idle_pct)) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    @(posedge clk_i);
    sb.note_item(it);
    sent++;
  endtask

  task automatic send_trajectory(int len, int term_pct);
    item_t it;
    for (int i = 0; i < len; i++) begin
      it.reward          = pick_word();
      it.state_value     = pick_word();
      it.bootstrap_value = pick_word();
      it.terminal        = ($urandom_range(0, 99) < term_pct);
      it.last            = (i == len - 1);
      send_step(it);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.expected_results.size() != 0 || busy) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // only while idle
  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    if (idx == CFG_DISCOUNT) sb.discount_q16 = val;
    else sb.decay_q16 = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_factors(logic [CFG_W-1:0] g, logic [CFG_W-1:0] l);
    drain();
    write_reg(CFG_DISCOUNT, g);
    write_reg(CFG_TRACE_DECAY, l);
  endtask

  initial begin
    item_t it;
    int    len;
    start      = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_DISCOUNT;
    cfg_data_i = '0;
    idle_pct   = 0;
    sent       = 0;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: single step extremes, saturation, terminal restart
    it = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b1};
    send_step(it);
    it = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0};
    send_step(it);
    it = '{32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b0, 1'b0};
    send_step(it);
    it = '{32'h00010000, 32'h0, 32'h7FFFFFFF, 1'b0, 1'b1};
    send_step(it);
    send_trajectory(4, 50);
    set_factors(17'd0, 17'd0);
    send_trajectory(3, 0);
    set_factors(ONE_Q16, ONE_Q16);
    send_trajectory(5, 20);
    // factors above one act as one
    set_factors(17'h1FFFF, 17'h1FFFF);
    send_trajectory(3, 0);
    // overfull buffer: extra steps dropped, last overwrites final slot
    idle_pct = 0;
    send_trajectory(DEPTH + 2, 10);

    set_factors(DISCOUNT_RST, TRACE_DECAY_RST);
    while (sent < 170) begin
      if (sent < 115) idle_pct = 33;
      else if (sent < 145) idle_pct = 59;
      else idle_pct = 0;
      if ($urandom_range(0, 5) == 0)
        set_factors(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
      len = ($urandom_range(0, 19) == 0) ? DEPTH : $urandom_range(1, 8);
      if (len > 170 - sent) len = 170 - sent;
      send_trajectory(len, $urandom_range(0, 40));
    end

    drain();
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gae_pkg.sv
hdl/gae_div.sv
hdl/gae_sqrt.sv
hdl/generalized_advantage_estimator_core.sv
tb/generalized_advantage_estimator_core_tb.sv
